FILE: rtl/cmm_pkg.sv
// Shared types and codes for the button combo maintenance menu.
`default_nettype none
package cmm_pkg;

    localparam int unsigned BUTTON_COUNT = 4;

    // input modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_COMBO  = 2'd1;
    localparam logic [1:0] MODE_BUTTON = 2'd2;

    // button event kinds
    localparam logic [1:0] EV_DOWN    = 2'd0;
    localparam logic [1:0] EV_UP      = 2'd1;
    localparam logic [1:0] EV_PRESSED = 2'd2;

    // menu phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_HELD      = 4'd1;
    localparam logic [3:0] PH_RELEASED  = 4'd2;
    localparam logic [3:0] PH_RESET     = 4'd3;
    localparam logic [3:0] PH_OPEN      = 4'd4;
    localparam logic [3:0] PH_CONF_OFF  = 4'd5;
    localparam logic [3:0] PH_CONF_ON   = 4'd6;
    localparam logic [3:0] PH_CONF_DEEP = 4'd7;
    localparam logic [3:0] PH_CONF_EXIT = 4'd8;
    localparam logic [3:0] PH_CLOSING   = 4'd9;

    // LED modes
    localparam logic [1:0] LED_NONE    = 2'd0;
    localparam logic [1:0] LED_OFF     = 2'd1;
    localparam logic [1:0] LED_FLICKER = 2'd2;
    localparam logic [1:0] LED_MEDIUM  = 2'd3;

    // action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_REBOOT    = 3'd1;
    localparam logic [2:0] ACT_TIMEOUT   = 3'd2;
    localparam logic [2:0] ACT_SLEEP_OFF = 3'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_COMBO_MASK     = 3'd0;
    localparam logic [2:0] CFG_REBOOT_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_MENU_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_CONFIRM_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_RELEASE_IGNORE = 3'd4;

    localparam int unsigned CFG_DATA_W = 20;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] event_kind;
        logic [2:0] button;
    } item_t;

    typedef struct packed {
        logic [3:0] menu_state;
        logic [1:0] led_mode;
        logic [2:0] action;
    } result_t;

    typedef struct packed {
        logic [7:0]  combo_mask;
        logic [19:0] reboot_timeout_ms;
        logic [19:0] menu_timeout_ms;
        logic [19:0] confirm_timeout_ms;
        logic [15:0] release_ignore_ms;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/cmm_if.sv
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface cmm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] event_kind;
    logic [2:0] button;

    modport source (output valid, output mode, output event_kind, output button, input ready);
    modport sink (input valid, input mode, input event_kind, input button, output ready);
endinterface

interface cmm_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] menu_state;
    logic [1:0] led_mode;
    logic [2:0] action;

    modport source (output valid, output menu_state, output led_mode, output action, input ready);
    modport sink (input valid, input menu_state, input led_mode, input action, output ready);
endinterface
`default_nettype wire

FILE: rtl/button_combo_maintenance_menu.sv
// Top level of the button combo maintenance menu controller.
// Usage:
//   evt carries one item per transfer: a millisecond tick, a combo-pressed
//   event or a single button event (down, up, pressed) with its button index.
//   res carries exactly one result per item: menu phase, LED mode, action.
//   wr_en/wr_index/wr_data write the five timing and mask registers; write
//   only while no item is in flight.
// Output: the result of an item is registered and is on res in the cycle after its transfer.
// Throughput: one item per cycle while res is ready; the state update and
//   all timeout compares and deadline sums are combinational, between the
//   input transfer and the result register.
// Reset: time, deadline, ignore window and held mask clear, the menu goes
//   idle and registers take their default values; res is empty.
// Stall: while res is held off, the result register keeps its item and evt
//   stops taking items until the result moves on; with res ready, evt.ready
//   stays high.
`default_nettype none
module button_combo_maintenance_menu
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [2:0]                      wr_index,
    input  wire logic [cmm_pkg::CFG_DATA_W-1:0]  wr_data,
    cmm_item_if.sink                             evt,
    cmm_result_if.source                         res
);
    import cmm_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    space;
    logic    fire;

    assign item.mode       = evt.mode;
    assign item.event_kind = evt.event_kind;
    assign item.button     = evt.button;
    assign evt.ready       = space;
    assign fire            = evt.valid && space;

    cmm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    cmm_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    cmm_out u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire),
        .result (result),
        .space  (space),
        .res    (res)
    );

endmodule
`default_nettype wire

FILE: rtl/cmm_cfg.sv
// Configuration register file with write-only access.
`default_nettype none
module cmm_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [2:0]                      wr_index,
    input  wire logic [cmm_pkg::CFG_DATA_W-1:0]  wr_data,
    output cmm_pkg::cfg_t                        cfg
);
    import cmm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.combo_mask         <= 8'd9;
            cfg_reg.reboot_timeout_ms  <= 20'd5000;
            cfg_reg.menu_timeout_ms    <= 20'd30000;
            cfg_reg.confirm_timeout_ms <= 20'd2000;
            cfg_reg.release_ignore_ms  <= 16'd750;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_COMBO_MASK:      cfg_reg.combo_mask         <= wr_data[7:0];
                CFG_REBOOT_TIMEOUT:  cfg_reg.reboot_timeout_ms  <= wr_data[19:0];
                CFG_MENU_TIMEOUT:    cfg_reg.menu_timeout_ms    <= wr_data[19:0];
                CFG_CONFIRM_TIMEOUT: cfg_reg.confirm_timeout_ms <= wr_data[19:0];
                CFG_RELEASE_IGNORE:  cfg_reg.release_ignore_ms  <= wr_data[15:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/cmm_core.sv
// Menu state registers and the per-item next-state logic.
`default_nettype none
module cmm_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire cmm_pkg::item_t  item,
    input  wire cmm_pkg::cfg_t   cfg,
    output cmm_pkg::result_t     result
);
    import cmm_pkg::*;

    logic [31:0] now_reg, now_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] ignore_reg, ignore_next;
    logic [7:0]  held_reg, held_next;
    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  led;
    logic [2:0]  act;
    logic [31:0] now_inc;
    logic [7:0]  bit_mask;
    logic        accept_evt;

    assign now_inc    = now_reg + 32'd1;
    assign accept_evt = (phase_reg != PH_HELD) && (now_reg > ignore_reg);
    assign bit_mask   = (32'(item.button) < BUTTON_COUNT) ? (8'd1 << item.button) : 8'd0;

    always_comb
    begin
        now_next      = now_reg;
        deadline_next = deadline_reg;
        ignore_next   = ignore_reg;
        held_next     = held_reg;
        phase_next    = phase_reg;
        led           = LED_NONE;
        act           = ACT_NONE;
        case (item.mode)
            MODE_TICK:
            begin
                now_next = now_inc;
                if (phase_reg != PH_IDLE)
                begin
                    if (now_inc >= deadline_reg)
                    begin
                        act           = (phase_reg == PH_HELD) ? ACT_REBOOT : ACT_TIMEOUT;
                        led           = LED_OFF;
                        deadline_next = 32'd0;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        case (phase_reg) inside
                            PH_RELEASED, PH_RESET:
                            begin
                                led           = LED_MEDIUM;
                                deadline_next = now_inc + 32'(cfg.menu_timeout_ms);
                                phase_next    = PH_OPEN;
                            end
                            [PH_CONF_OFF:PH_CONF_EXIT]:
                            begin
                                led           = LED_FLICKER;
                                act           = 3'(phase_reg - PH_CONF_OFF) + ACT_SLEEP_OFF;
                                deadline_next = now_inc + 32'(cfg.confirm_timeout_ms);
                                phase_next    = PH_CLOSING;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            MODE_COMBO:
            begin
                ignore_next   = now_reg;
                deadline_next = now_reg + 32'(cfg.reboot_timeout_ms);
                phase_next    = PH_HELD;
                led           = LED_FLICKER;
            end
            MODE_BUTTON:
            begin
                case (item.event_kind)
                    EV_DOWN:
                    begin
                        if (accept_evt && phase_reg == PH_OPEN)
                        begin
                            phase_next = PH_RESET;
                            led        = LED_FLICKER;
                        end
                        held_next = held_reg | bit_mask;
                    end
                    EV_UP:
                    begin
                        held_next = held_reg & ~bit_mask;
                    end
                    EV_PRESSED:
                    begin
                        if (accept_evt && !item.button[2])
                        begin
                            phase_next = PH_CONF_OFF + 4'(item.button[1:0]);
                            led        = LED_FLICKER;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // combo fully released while held: the next tick opens the menu unless the reboot deadline is reached
                if ((held_next & cfg.combo_mask) == 8'd0 && phase_next == PH_HELD)
                begin
                    phase_next  = PH_RELEASED;
                    led         = LED_FLICKER;
                    ignore_next = now_reg + 32'(cfg.release_ignore_ms);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            deadline_reg <= '0;
            ignore_reg   <= '0;
            held_reg     <= '0;
            phase_reg    <= PH_IDLE;
        end
        else if (fire)
        begin
            now_reg      <= now_next;
            deadline_reg <= deadline_next;
            ignore_reg   <= ignore_next;
            held_reg     <= held_next;
            phase_reg    <= phase_next;
        end
    end

    assign result.menu_state = phase_next;
    assign result.led_mode   = led;
    assign result.action     = act;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_CLOSING)
        else $error("menu phase out of range");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.mode == MODE_TICK |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance time");

    a_action_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && act != ACT_NONE |-> item.mode == MODE_TICK)
        else $error("action outside a tick");

    a_expiry_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (act == ACT_REBOOT || act == ACT_TIMEOUT)
        |=> phase_reg == PH_IDLE && deadline_reg == 32'd0)
        else $error("expiry did not return to idle");

endmodule
`default_nettype wire

FILE: rtl/cmm_out.sv
// Result register between the core and the output channel.
`default_nettype none
module cmm_out
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire cmm_pkg::result_t  result,
    output logic                   space,
    cmm_result_if.source           res
);
    import cmm_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign space = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload holds while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid      = valid_reg;
    assign res.menu_state = data_reg.menu_state;
    assign res.led_mode   = data_reg.led_mode;
    assign res.action     = data_reg.action;

endmodule
`default_nettype wire

FILE: bench/tb_button_combo_maintenance_menu.sv
// Self-checking bench for the button combo maintenance menu controller.
`timescale 1ns / 100ps
module tb_button_combo_maintenance_menu;
    import cmm_pkg::*;

    localparam logic [1:0] MODE_NONE        = 2'd3;
    localparam logic [1:0] EV_OTHER         = 2'd3;
    localparam logic [2:0] LAST_MENU_BUTTON = 3'd3;
    localparam int         IDLE_PCT         = 27;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam int         SETTLE_CYCLES    = 4;
    localparam int         PHASE_COUNT      = 10;

    // Tracks the menu state and the outcomes still owed by the block.
    class menu_tracker;
        cfg_t        cfg;
        logic [31:0] clock_ms;
        logic [31:0] deadline;
        logic [31:0] quiet_until;
        logic [7:0]  held;
        logic [3:0]  phase;
        result_t     owed_outcomes[$];
        int          errors;

        function new();
            cfg.combo_mask         = 8'd9;
            cfg.reboot_timeout_ms  = 20'd5000;
            cfg.menu_timeout_ms    = 20'd30000;
            cfg.confirm_timeout_ms = 20'd2000;
            cfg.release_ignore_ms  = 16'd750;
            clock_ms    = '0;
            deadline    = '0;
            quiet_until = '0;
            held        = '0;
            phase       = PH_IDLE;
            errors      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COMBO_MASK:      cfg.combo_mask         = data[7:0];
                CFG_REBOOT_TIMEOUT:  cfg.reboot_timeout_ms  = data[19:0];
                CFG_MENU_TIMEOUT:    cfg.menu_timeout_ms    = data[19:0];
                CFG_CONFIRM_TIMEOUT: cfg.confirm_timeout_ms = data[19:0];
                CFG_RELEASE_IGNORE:  cfg.release_ignore_ms  = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_outcomes.size();
        endfunction

        // Advance the menu by one accepted item and queue its outcome.
        function void note_item(item_t it);
            result_t     r;
            logic [7:0]  btn_bit;
            logic        open_to_input;
            r.led_mode = LED_NONE;
            r.action   = ACT_NONE;
            case (it.mode)
                MODE_TICK:
                begin
                    clock_ms = clock_ms + 32'd1;
                    if (phase != PH_IDLE)
                    begin
                        if (clock_ms >= deadline)
                        begin
                            r.action   = (phase == PH_HELD) ? ACT_REBOOT : ACT_TIMEOUT;
                            r.led_mode = LED_OFF;
                            deadline   = '0;
                            phase      = PH_IDLE;
                        end
                        else if (phase == PH_RELEASED || phase == PH_RESET)
                        begin
                            r.led_mode = LED_MEDIUM;
                            deadline   = clock_ms + cfg.menu_timeout_ms;
                            phase      = PH_OPEN;
                        end
                        else if (phase >= PH_CONF_OFF && phase <= PH_CONF_EXIT)
                        begin
                            r.led_mode = LED_FLICKER;
                            r.action   = ACT_SLEEP_OFF + 3'(phase - PH_CONF_OFF);
                            deadline   = clock_ms + cfg.confirm_timeout_ms;
                            phase      = PH_CLOSING;
                        end
                    end
                end
                MODE_COMBO:
                begin
                    quiet_until = clock_ms;
                    deadline    = clock_ms + cfg.reboot_timeout_ms;
                    phase       = PH_HELD;
                    r.led_mode  = LED_FLICKER;
                end
                MODE_BUTTON:
                begin
                    open_to_input = (phase != PH_HELD) && (clock_ms > quiet_until);
                    btn_bit = (it.button < BUTTON_COUNT) ? (8'd1 << it.button) : 8'd0;
                    case (it.event_kind)
                        EV_DOWN:
                        begin
                            if (open_to_input && phase == PH_OPEN)
                            begin
                                phase      = PH_RESET;
                                r.led_mode = LED_FLICKER;
                            end
                            held = held | btn_bit;
                        end
                        EV_UP:
                            held = held & ~btn_bit;
                        EV_PRESSED:
                        begin
                            if (open_to_input && it.button <= LAST_MENU_BUTTON)
                            begin
                                phase      = PH_CONF_OFF + 4'(it.button);
                                r.led_mode = LED_FLICKER;
                            end
                        end
                        default: ;
                    endcase
                    // combo fully let go while held: start the quiet window; the next tick opens the menu
                    if ((held & cfg.combo_mask) == 8'd0 && phase == PH_HELD)
                    begin
                        phase       = PH_RELEASED;
                        r.led_mode  = LED_FLICKER;
                        quiet_until = clock_ms + cfg.release_ignore_ms;
                    end
                end
                default: ;
            endcase
            r.menu_state = phase;
            owed_outcomes.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (owed_outcomes.size() == 0)
            begin
                report($sformatf("unexpected result state=%0d led=%0d action=%0d",
                                 got.menu_state, got.led_mode, got.action));
            end
            else
            begin
                want = owed_outcomes.pop_front();
                if (got.menu_state !== want.menu_state)
                    report($sformatf("menu_state got %0d want %0d",
                                     got.menu_state, want.menu_state));
                if (got.led_mode !== want.led_mode)
                    report($sformatf("led_mode got %0d want %0d", got.led_mode, want.led_mode));
                if (got.action !== want.action)
                    report($sformatf("action got %0d want %0d", got.action, want.action));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [2:0]             wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    bit                     no_idle = 1'b0;
    int                     items_sent = 0;
    int                     cycle_count = 0;
    menu_tracker            tracker = new();

    cmm_item_if   evt_ch();
    cmm_result_if res_ch();

    button_combo_maintenance_menu i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .evt      (evt_ch),
        .res      (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check each transfer, stall at random.
    initial
    begin
        result_t got;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.menu_state = res_ch.menu_state;
                got.led_mode   = res_ch.led_mode;
                got.action     = res_ch.action;
                tracker.check_result(got);
            end
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic item_t pack_item(logic [1:0] m, logic [1:0] k, logic [2:0] b);
        item_t it;
        it.mode       = m;
        it.event_kind = k;
        it.button     = b;
        return it;
    endfunction

    function automatic int span(int unsigned v);
        return (v > 40) ? 42 : int'(v) + 2;
    endfunction

    function automatic logic [2:0] pick_button();
        return ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 3))
                                            : 3'($urandom_range(4, 7));
    endfunction

    // Present one item and hold it until the transfer.
    task automatic send_item(item_t it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.mode       <= it.mode;
        evt_ch.event_kind <= it.event_kind;
        evt_ch.button     <= it.button;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        tracker.note_item(it);
        items_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_item(pack_item(MODE_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 15)
            send_item(pack_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7))));
    endtask

    // Drop valid and wait until every owed outcome has come back.
    task automatic drain();
        evt_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [7:0] mask, logic [19:0] reboot, logic [19:0] menu,
                                logic [19:0] confirm, logic [15:0] quiet);
        logic [CFG_DATA_W-1:0] vals[5];
        vals[CFG_COMBO_MASK]      = CFG_DATA_W'(mask);
        vals[CFG_REBOOT_TIMEOUT]  = reboot;
        vals[CFG_MENU_TIMEOUT]    = menu;
        vals[CFG_CONFIRM_TIMEOUT] = confirm;
        vals[CFG_RELEASE_IGNORE]  = CFG_DATA_W'(quiet);
        for (int i = 0; i < 5; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= 3'(i);
            wr_data  <= vals[i];
            @(posedge clk);
            tracker.write_reg(3'(i), vals[i]);
        end
        wr_en <= 1'b0;
    endtask

    // One combo hold, release and menu choice with random timing and noise.
    task automatic run_session();
        logic [2:0] downs[$];
        int         pick;
        int         choice;
        if ($urandom_range(0, 99) < 90)
            send_item(pack_item(MODE_COMBO, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
        repeat ($urandom_range(0, 3))
        begin
            downs.push_back(pick_button());
            send_item(pack_item(MODE_BUTTON, EV_DOWN, downs[$]));
        end
        send_ticks($urandom_range(0, span(tracker.cfg.reboot_timeout_ms)));
        while (downs.size() > 0)
        begin
            pick = $urandom_range(0, downs.size() - 1);
            if ($urandom_range(0, 99) < 85)
                send_item(pack_item(MODE_BUTTON, EV_UP, downs[pick]));
            downs.delete(pick);
            maybe_noise();
        end
        // an empty combo mask releases on any button event
        send_item(pack_item(MODE_BUTTON, EV_OTHER, 3'($urandom_range(0, 7))));
        send_ticks($urandom_range(0, span(tracker.cfg.release_ignore_ms)));
        choice = $urandom_range(0, 99);
        if (choice < 70)
            send_item(pack_item(MODE_BUTTON, EV_PRESSED, pick_button()));
        else if (choice < 85)
            send_item(pack_item(MODE_BUTTON, EV_DOWN, pick_button()));
        else
            maybe_noise();
        send_ticks($urandom_range(0, span(tracker.cfg.menu_timeout_ms) / 2));
        maybe_noise();
        send_ticks($urandom_range(0, span(tracker.cfg.confirm_timeout_ms)
                                     + span(tracker.cfg.menu_timeout_ms)));
    endtask

    initial
    begin
        int quota;
        int start_count;
        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= CFG_COMBO_MASK;
        wr_data           <= '0;
        evt_ch.valid      <= 1'b0;
        evt_ch.mode       <= MODE_TICK;
        evt_ch.event_kind <= EV_DOWN;
        evt_ch.button     <= 3'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through the menu, reset values first
        send_item(pack_item(MODE_NONE, EV_OTHER, 3'd7));
        send_item(pack_item(MODE_TICK, EV_DOWN, 3'd0));
        send_item(pack_item(MODE_BUTTON, EV_PRESSED, 3'd0));
        send_item(pack_item(MODE_COMBO, EV_DOWN, 3'd0));
        send_item(pack_item(MODE_BUTTON, EV_DOWN, 3'd0));
        send_item(pack_item(MODE_BUTTON, EV_DOWN, 3'd3));
        send_item(pack_item(MODE_BUTTON, EV_UP, 3'd0));
        drain();
        write_config(8'h09, 20'd3, 20'd4, 20'd2, 16'd2);
        send_item(pack_item(MODE_BUTTON, EV_UP, 3'd3));
        send_ticks(3);
        send_item(pack_item(MODE_BUTTON, EV_DOWN, 3'd1));
        send_ticks(1);
        send_item(pack_item(MODE_BUTTON, EV_OTHER, 3'd5));
        send_item(pack_item(MODE_BUTTON, EV_DOWN, 3'd7));
        send_ticks(1);
        send_item(pack_item(MODE_BUTTON, EV_PRESSED, 3'd7));
        send_item(pack_item(MODE_BUTTON, EV_PRESSED, 3'd3));
        send_ticks(1);
        send_item(pack_item(MODE_BUTTON, EV_PRESSED, 3'd2));
        send_ticks(3);
        send_item(pack_item(MODE_COMBO, EV_OTHER, 3'd7));
        send_ticks(3);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                    write_config(8'h00, 20'd1, 20'd1, 20'd1, 16'd0);
                PHASE_COUNT - 1:
                    write_config(8'hFF, 20'd600000, 20'd600000, 20'd600000, 16'hFFFF);
                default:
                    write_config(8'($urandom_range(1, 255)), 20'($urandom_range(1, 12)),
                                 20'($urandom_range(1, 16)), 20'($urandom_range(1, 8)),
                                 16'($urandom_range(0, 6)));
            endcase
            no_idle = (ph == 4);
            quota = (ph == PHASE_COUNT - 1) ? 60 : 150;
            start_count = items_sent;
            while (items_sent - start_count < quota)
                run_session();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cmm_pkg.sv
rtl/cmm_if.sv
rtl/cmm_cfg.sv
rtl/cmm_core.sv
rtl/cmm_out.sv
rtl/button_combo_maintenance_menu.sv
bench/tb_button_combo_maintenance_menu.sv
